FILE: hdl/pic_pkg.sv
`default_nettype none
package pic_pkg;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_CLS, S_EXEC, S_TH, S_SCAN, S_DRAIN, S_LINE, S_CLAIM, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    K_NONE, K_PRIO_RD, K_PRIO_WR, K_PEND_RD, K_EN_RD, K_EN_WR,
    K_TH_RD, K_TH_WR, K_CLAIM, K_COMPLETE, K_SRC, K_REFRESH
  } kind_t;

  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_SOURCE  = 2'd2;
  localparam logic [1:0] ACT_REFRESH = 2'd3;

  localparam logic [31:0] PRIO_END  = 32'h0000_1000;
  localparam logic [31:0] PEND_BASE = 32'h0000_1000;
  localparam logic [31:0] PEND_END  = 32'h0000_1080;
  localparam logic [31:0] EN_BASE   = 32'h0000_2000;
  localparam logic [31:0] TH_BASE   = 32'h0020_0000;
  localparam logic [31:0] TH_STRIDE = 32'h0000_1000;
  localparam logic [13:0] EN_CTX_OFS = 14'(EN_BASE >> 7);   // 0x80 per context
  localparam logic [19:0] TH_CTX_OFS = 20'(TH_BASE >> 12);
  localparam logic [11:0] SUB_CLAIM  = 12'h004;
  localparam logic [31:0] PRIO_MASK  = 32'h7FFF_FFFF;
  localparam int PRIO_W = 31;

  localparam logic [1:0] REG_BASE = 2'd0;

  typedef struct packed {
    logic latch;
    logic dec;
    logic cls;
    logic exec;
    logic clr_step;
    logic scan_init;
    logic scan_issue;
    logic line_upd;
    logic ctx_next;
    logic claim_save;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  id_last;
    logic  ctx_last;
    logic  best_nz;
  } stat_t;

  function automatic logic refreshes_all(kind_t k);
    return (k == K_PRIO_WR) || (k == K_SRC) || (k == K_REFRESH);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/platform_interrupt_controller.sv
`default_nettype none
// Platform interrupt controller. Pulse start while busy is low to hand over one
// transfer (bus read, bus write, source pending update or refresh of all lines);
// busy rises the next cycle, and done pulses for exactly one cycle with read_data
// and irq_lines, which the receiver must take then: it cannot stall the block.
// Reads, ignored accesses and pending reads go through the decode, classify and
// execute states and then raise done; busy drops in the cycle after done. Anything
// that re-evaluates a context adds a winner scan of one source per cycle over the
// priority and enable memories: once for enable, threshold and completion writes
// and for a claim that finds no winner, twice for a claim that finds one, and
// 2*HART_COUNT times, once per context, for priority writes, source updates and
// refreshes. After reset the block clears its memories with busy high; the base
// address register stays writable.
module platform_interrupt_controller #(
  parameter int SRC_MAX    = 63,
  parameter int HART_COUNT = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] address,
  input  wire logic        word_access,
  input  wire logic [31:0] write_data,
  input  wire logic [9:0]  src_id,
  input  wire logic        pending_level,
  output logic             done,
  output logic [31:0]      read_data,
  output logic [3:0]       irq_lines,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pic_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] base_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) base_address <= '0;
    else if (psel && penable && pwrite && pready && ((paddr >> 2) == REG_BASE))
      base_address <= pwdata;
  end

  assign prdata = ((paddr >> 2) == REG_BASE) ? base_address : 32'd0;

  pic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  pic_dp #(
    .SRC_MAX    (SRC_MAX),
    .HART_COUNT (HART_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .base_address  (base_address),
    .action        (action),
    .address       (address),
    .word_access   (word_access),
    .write_data    (write_data),
    .src_id        (src_id),
    .pending_level (pending_level),
    .read_data     (read_data),
    .irq_lines     (irq_lines)
  );

endmodule
`default_nettype wire

FILE: hdl/pic_ctrl.sv
`default_nettype none
module pic_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  output pic_pkg::cmd_t      cmd,
  input  wire pic_pkg::stat_t stat
);
  import pic_pkg::*;

  state_t state, state_next;
  logic   second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd         = '0;
    busy        = (state != S_IDLE);
    done        = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          second_next = 1'b0;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = S_CLS;
      end
      S_CLS: begin
        cmd.cls    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.kind)
          K_PRIO_WR, K_SRC, K_REFRESH, K_EN_WR, K_TH_WR, K_COMPLETE, K_CLAIM:
            state_next = S_TH;
          default: state_next = S_DONE;
        endcase
      end
      S_TH: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.id_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.kind == K_CLAIM && !second) state_next = S_CLAIM;
        else state_next = S_LINE;
      end
      S_CLAIM: begin
        // winner's pending bit drops here; if there was a winner, the line is searched again
        cmd.claim_save = 1'b1;
        if (stat.best_nz) begin
          second_next = 1'b1;
          state_next  = S_TH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LINE: begin
        cmd.line_upd = 1'b1;
        if (refreshes_all(stat.kind) && !stat.ctx_last) begin
          cmd.ctx_next = 1'b1;
          state_next   = S_TH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/pic_dp.sv
`default_nettype none
module pic_dp #(
  parameter int SRC_MAX    = 63,
  parameter int HART_COUNT = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pic_pkg::cmd_t  cmd,
  output pic_pkg::stat_t      stat,
  input  wire logic [31:0]    base_address,
  input  wire logic [1:0]     action,
  input  wire logic [31:0]    address,
  input  wire logic           word_access,
  input  wire logic [31:0]    write_data,
  input  wire logic [9:0]     src_id,
  input  wire logic           pending_level,
  output logic [31:0]         read_data,
  output logic [3:0]          irq_lines
);
  import pic_pkg::*;

  localparam int NCTX   = 2 * HART_COUNT;
  localparam int NWORDS = SRC_MAX / 32 + 1;
  localparam int CW     = $clog2(NCTX);
  localparam int IW     = $clog2(SRC_MAX + 1);
  localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PD     = 1 << IW;
  localparam int ED     = 1 << (CW + WW);
  localparam int TD     = 1 << CW;
  localparam int CLR_N  = (PD > ED) ? PD : ED;
  localparam int CLRW   = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [32:0] TH_END = 33'(TH_BASE) + 33'(NCTX) * 33'(TH_STRIDE);

  // transfer capture
  logic [1:0]  act_q;
  logic [31:0] addr_q, data_q;
  logic        word_q, lvl_q;
  logic [9:0]  src_q;
  logic [31:0] off_q;
  logic        below_q;

  kind_t          kind_q, dec_kind;
  logic [CW-1:0]  ctx_q, dec_ctx;
  logic [WW-1:0]  widx_q;
  logic [IW-1:0]  pidx_q;

  logic [PRIO_W-1:0] prio_mem [PD];
  logic [31:0]       en_mem [ED];
  logic [PRIO_W-1:0] thr_mem [TD];
  logic [PRIO_W-1:0] prio_q, thr_q;
  logic [31:0]       en_q;
  logic [SRC_MAX:0]  pend;
  logic [NCTX-1:0]   line;
  logic [CLRW-1:0]   clr_q;

  logic [IW-1:0]     id_q, id_d, best_id;
  logic [PRIO_W-1:0] best_p;
  logic              cmp_v, hit;
  logic [31:0]       rd_q;

  logic [IW-1:0]      prio_ra;
  logic [CW+WW-1:0]   en_ra;
  logic [CW-1:0]      thr_ra;
  logic [(1<<WW)*32-1:0] pend_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= action;
      addr_q <= address;
      word_q <= word_access;
      data_q <= write_data;
      src_q  <= src_id;
      lvl_q  <= pending_level;
    end
    if (cmd.dec) begin
      off_q   <= addr_q - base_address;
      below_q <= (addr_q < base_address);
    end
  end

  // region decode on the registered offset
  always_comb begin
    logic [13:0] en_c;
    logic [19:0] th_c;
    logic [11:0] sub;
    logic [9:0]  p_idx;
    logic [4:0]  w;
    logic        wr;
    en_c     = off_q[20:7] - EN_CTX_OFS;
    th_c     = off_q[31:12] - TH_CTX_OFS;
    sub      = off_q[11:0];
    p_idx    = off_q[11:2];
    w        = off_q[6:2];
    wr       = (act_q == ACT_WRITE);
    dec_kind = K_NONE;
    dec_ctx  = '0;
    unique case (act_q)
      ACT_READ, ACT_WRITE: begin
        if (word_q && !below_q) begin
          if (off_q < PRIO_END) begin
            if (p_idx != 10'd0 && 32'(p_idx) <= 32'(SRC_MAX))
              dec_kind = wr ? K_PRIO_WR : K_PRIO_RD;
          end else if (off_q >= PEND_BASE && off_q < PEND_END) begin
            if (!wr && 32'(w) < 32'(NWORDS)) dec_kind = K_PEND_RD;
          end else if (off_q >= EN_BASE && off_q < TH_BASE) begin
            dec_ctx = CW'(en_c);
            if (32'(en_c) < 32'(NCTX) && 32'(w) < 32'(NWORDS))
              dec_kind = wr ? K_EN_WR : K_EN_RD;
          end else if ({1'b0, off_q} >= 33'(TH_BASE) && {1'b0, off_q} < TH_END) begin
            dec_ctx = CW'(th_c);
            if (sub == 12'd0) begin
              dec_kind = wr ? K_TH_WR : K_TH_RD;
            end else if (sub == SUB_CLAIM) begin
              if (!wr) dec_kind = K_CLAIM;
              else if (data_q != 32'd0 && data_q <= 32'(SRC_MAX)) dec_kind = K_COMPLETE;
            end
          end
        end
      end
      ACT_SOURCE: begin
        if (src_q != 10'd0 && 32'(src_q) <= 32'(SRC_MAX)) dec_kind = K_SRC;
      end
      ACT_REFRESH: dec_kind = K_REFRESH;
      default: dec_kind = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_q <= K_NONE;
      ctx_q  <= '0;
    end else if (cmd.cls) begin
      kind_q <= dec_kind;
      ctx_q  <= refreshes_all(dec_kind) ? '0 : dec_ctx;
    end else if (cmd.ctx_next) begin
      ctx_q <= ctx_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cls) begin
      widx_q <= WW'(off_q[6:2]);
      pidx_q <= IW'(off_q[11:2]);
    end
  end

  // outside a scan the addresses come straight from the decode, so register reads
  // are ready in the execute cycle
  assign prio_ra = cmd.scan_issue ? id_q : IW'(off_q[11:2]);
  assign en_ra   = cmd.scan_issue ? {ctx_q, WW'(id_q >> 5)} : {dec_ctx, WW'(off_q[6:2])};
  assign thr_ra  = cmd.cls ? dec_ctx : ctx_q;

  // memories: clearing sweep after reset, then bus writes
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      prio_mem[clr_q[IW-1:0]]    <= '0;
      en_mem[clr_q[CW+WW-1:0]]   <= '0;
      thr_mem[clr_q[CW-1:0]]     <= '0;
    end else if (cmd.exec) begin
      if (kind_q == K_PRIO_WR) prio_mem[pidx_q] <= PRIO_W'(data_q & PRIO_MASK);
      if (kind_q == K_EN_WR)   en_mem[{ctx_q, widx_q}] <= data_q;
      if (kind_q == K_TH_WR)   thr_mem[ctx_q] <= PRIO_W'(data_q & PRIO_MASK);
    end
    prio_q <= prio_mem[prio_ra];
    en_q   <= en_mem[en_ra];
    thr_q  <= thr_mem[thr_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_q <= '0;
    else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (cmd.exec && kind_q == K_SRC) begin
      pend[IW'(src_q)] <= lvl_q;
    end else if (cmd.exec && kind_q == K_COMPLETE) begin
      pend[IW'(data_q)] <= 1'b0;
    end else if (cmd.claim_save && best_id != '0) begin
      pend[best_id] <= 1'b0;
    end
  end

  assign pend_ext = ((1<<WW)*32)'(pend);

  // winner scan: issue one source a cycle, compare it the next
  assign hit = cmp_v && pend[id_d] && en_q[5'(id_d)] &&
               (prio_q > thr_q) && (prio_q > best_p);

  always_ff @(posedge clk) begin
    cmp_v <= cmd.scan_issue;
    if (cmd.scan_issue) id_d <= id_q;
    if (cmd.scan_init) begin
      id_q    <= IW'(1);
      best_id <= '0;
      best_p  <= '0;
    end else begin
      if (cmd.scan_issue) id_q <= id_q + 1'b1;
      if (hit) begin
        best_id <= id_d;
        best_p  <= prio_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) line <= '0;
    else if (cmd.line_upd) line[ctx_q] <= (best_id != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (kind_q)
        K_PRIO_RD: rd_q <= 32'(prio_q);
        K_PEND_RD: rd_q <= pend_ext[widx_q*32 +: 32];
        K_EN_RD:   rd_q <= en_q;
        K_TH_RD:   rd_q <= 32'(thr_q);
        default:   rd_q <= 32'd0;
      endcase
    end else if (cmd.claim_save) begin
      rd_q <= 32'(best_id);
    end
  end

  assign read_data = rd_q;
  assign irq_lines = 4'(line);

  always_comb begin
    stat.kind     = kind_q;
    stat.clr_last = (clr_q == CLRW'(CLR_N - 1));
    stat.id_last  = (id_q == IW'(SRC_MAX));
    stat.ctx_last = (ctx_q == CW'(NCTX - 1));
    stat.best_nz  = (best_id != '0);
  end

endmodule
`default_nettype wire

FILE: sim/platform_interrupt_controller_tb.sv
`timescale 1ns / 1ps
module platform_interrupt_controller_tb;
  import pic_pkg::*;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] addr;
    logic        word;
    logic [31:0] data;
    logic [9:0]  src;
    logic        lvl;
  } pic_item_t;

  typedef struct {
    logic [31:0] rdata;
    logic [3:0]  irq;
  } pic_result_t;

  localparam int NSRC = 63;
  localparam int NCTX = 4;

  // Behavioral model of the controller plus queue of results still owed by the DUT
  class pic_scoreboard;
    bit [30:0]   prio_tab[NSRC+1];
    bit [63:0]   pend;
    bit [31:0]   enables[NCTX][2];
    bit [30:0]   thresh[NCTX];
    bit [3:0]    lines;
    bit [31:0]   window_base;
    pic_result_t owed_q[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_claims;

    function int winner(int c);
      int best;
      bit [30:0] best_p;
      best = 0;
      best_p = 0;
      for (int id = 1; id <= NSRC; id++) begin
        if (pend[id] && enables[c][id >> 5][id & 31] && prio_tab[id] > thresh[c] &&
            prio_tab[id] > best_p) begin
          best_p = prio_tab[id];
          best = id;
        end
      end
      return best;
    endfunction

    function void refresh(int c);
      lines[c] = (winner(c) != 0);
    endfunction

    function void refresh_all();
      for (int c = 0; c < NCTX; c++) refresh(c);
    endfunction

    function bit [31:0] bus_access(bit wr, bit [31:0] a, bit [31:0] d);
      bit [31:0] off;
      int idx, c, w, id;
      bit [31:0] sub;
      if (a < window_base) return 0;
      off = a - window_base;
      if (off < 32'h1000) begin
        idx = off >> 2;
        if (idx < 1 || idx > NSRC) return 0;
        if (!wr) return {1'b0, prio_tab[idx]};
        prio_tab[idx] = d[30:0];
        refresh_all();
        return 0;
      end
      if (off >= 32'h1000 && off < 32'h1080) begin
        w = (off - 32'h1000) >> 2;
        if (wr || w >= 2) return 0;
        return w ? pend[63:32] : pend[31:0];
      end
      if (off >= 32'h2000 && off < 32'h20_0000) begin
        c = (off - 32'h2000) / 32'h80;
        w = ((off - 32'h2000) % 32'h80) >> 2;
        if (c >= NCTX || w >= 2) return 0;
        if (!wr) return enables[c][w];
        enables[c][w] = d;
        refresh(c);
        return 0;
      end
      if (off >= 32'h20_0000 && off < 32'h20_0000 + NCTX * 32'h1000) begin
        c = (off - 32'h20_0000) / 32'h1000;
        sub = (off - 32'h20_0000) % 32'h1000;
        if (sub == 0) begin
          if (!wr) return {1'b0, thresh[c]};
          thresh[c] = d[30:0];
          refresh(c);
        end else if (sub == 4) begin
          if (!wr) begin
            id = winner(c);
            if (id != 0) begin
              pend[id] = 1'b0;
              refresh(c);
              n_claims++;
            end
            return id;
          end
          if (d != 0 && d <= NSRC) begin
            pend[d] = 1'b0;
            refresh(c);
          end
        end
      end
      return 0;
    endfunction

    function void note_item(pic_item_t it);
      pic_result_t r;
      r.rdata = 0;
      case (it.act)
        ACT_READ:  if (it.word) r.rdata = bus_access(1'b0, it.addr, 0);
        ACT_WRITE: if (it.word) void'(bus_access(1'b1, it.addr, it.data));
        ACT_SOURCE:
          if (it.src != 0 && it.src <= NSRC) begin
            pend[it.src] = it.lvl;
            refresh_all();
          end
        default:   refresh_all();
      endcase
      r.irq = lines;
      owed_q.insert(owed_q.size(), r);
      n_items++;
    endfunction

    function void check(logic [31:0] rdata, logic [3:0] irq);
      pic_result_t e;
      n_results++;
      if (owed_q.size() == 0) begin
        $error("result with nothing outstanding: read_data %h irq_lines %h", rdata, irq);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (rdata !== e.rdata) begin
        $error("read_data mismatch: expected %h actual %h", e.rdata, rdata);
        errors++;
      end
      if (irq !== e.irq) begin
        $error("irq_lines mismatch: expected %h actual %h", e.irq, irq);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  action = ACT_READ;
  logic [31:0] address = 0;
  logic        word_access = 0;
  logic [31:0] write_data = 0;
  logic [9:0]  src_id = 0;
  logic        pending_level = 0;
  logic        done;
  logic [31:0] read_data;
  logic [3:0]  irq_lines;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  pic_scoreboard sb = new();

  platform_interrupt_controller u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .address(address), .word_access(word_access),
    .write_data(write_data), .src_id(src_id), .pending_level(pending_level),
    .done(done), .read_data(read_data), .irq_lines(irq_lines),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(read_data, irq_lines);
  end

  initial begin
    #60_000_000;
    $display("platform_interrupt_controller_tb: FAIL");
    $finish;
  end

  task automatic send(pic_item_t it, int idle_pct);
    @(negedge clk);
    action <= it.act;
    address <= it.addr;
    word_access <= it.word;
    write_data <= it.data;
    src_id <= it.src;
    pending_level <= it.lvl;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 300)) @(negedge clk);
      else repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed_q.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  // APB write of the window base; DUT must be idle
  task automatic set_base(logic [31:0] val);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(REG_BASE * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.window_base = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic pic_item_t mk(logic [1:0] act, logic [31:0] off, logic [31:0] d,
                                   logic [9:0] src = 0, logic lvl = 0, logic word = 1);
    pic_item_t it;
    it.act = act;
    it.addr = sb.window_base + off;
    it.word = word;
    it.data = d;
    it.src = src;
    it.lvl = lvl;
    return it;
  endfunction

  function automatic pic_item_t rand_item();
    pic_item_t it;
    logic [31:0] off, sub;
    int r;
    r = $urandom_range(99);
    if (r < 20) off = $urandom_range(0, 64) * 4;
    else if (r < 30) off = 32'h1000 + $urandom_range(0, 31) * 4;
    else if (r < 50) off = 32'h2000 + $urandom_range(0, 5) * 32'h80 +
                           ($urandom_range(3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 1)) * 4;
    else if (r < 92) begin
      sub = $urandom_range(9) == 0 ? $urandom_range(0, 32'hFFF) : $urandom_range(0, 1) * 4;
      off = 32'h20_0000 + $urandom_range(0, 4) * 32'h1000 + sub;
    end else off = $urandom;
    if ($urandom_range(15) == 0) off = off | $urandom_range(0, 3);
    it = mk(ACT_READ, off, 0);
    if ($urandom_range(19) == 0) it.addr = $urandom;
    it.word = $urandom_range(19) != 0;
    it.src = $urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(1, NSRC));
    it.lvl = $urandom_range(9) < 7;
    if (off < 32'h1000 || off[11:0] == 0) it.data = $urandom_range(4) == 0 ? $urandom : $urandom_range(0, 7);
    else if (off[11:0] == 4) it.data = $urandom_range(4) == 0 ? $urandom : $urandom_range(0, 66);
    else it.data = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
    r = $urandom_range(99);
    if (r < 35) it.act = ACT_SOURCE;
    else if (r < 58) it.act = ACT_WRITE;
    else if (r < 94) it.act = ACT_READ;
    else it.act = ACT_REFRESH;
    return it;
  endfunction

  task automatic rand_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      send(rand_item(), idle_pct);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_base(32'h0);
    // directed: extremes, ties, ignored and unmapped accesses
    send(mk(ACT_WRITE, 4 * 1, 32'hFFFF_FFFF), 0);
    send(mk(ACT_WRITE, 4 * NSRC, 32'h7FFF_FFFF), 0);
    send(mk(ACT_WRITE, 32'h2000, 32'hFFFF_FFFF), 0);
    send(mk(ACT_WRITE, 32'h2004, 32'hFFFF_FFFF), 0);
    send(mk(ACT_SOURCE, 0, 0, 10'd1, 1'b1), 0);
    send(mk(ACT_SOURCE, 0, 0, 10'd63, 1'b1), 0);
    send(mk(ACT_SOURCE, 0, 0, 10'd0, 1'b1), 0);
    send(mk(ACT_SOURCE, 0, 0, 10'h3FF, 1'b1), 0);
    send(mk(ACT_READ, 32'h1004, 0), 0);
    send(mk(ACT_WRITE, 32'h1000, 32'hFFFF_FFFF), 0);
    send(mk(ACT_READ, 32'h20_0004, 0), 0);
    send(mk(ACT_READ, 32'h20_0004, 0), 0);
    send(mk(ACT_READ, 32'h20_0004, 0), 0);
    send(mk(ACT_WRITE, 32'h20_0004, 32'd63), 0);
    send(mk(ACT_WRITE, 32'h20_0004, 32'd64), 0);
    send(mk(ACT_WRITE, 32'h20_0004, 32'd0), 0);
    send(mk(ACT_SOURCE, 0, 0, 10'd63, 1'b1), 0);
    send(mk(ACT_WRITE, 32'h20_0000, 32'hFFFF_FFFF), 0);
    send(mk(ACT_READ, 32'h20_0000, 0), 0);
    send(mk(ACT_READ, 32'h0, 0), 0);
    send(mk(ACT_READ, 4 * 64 + 3, 0), 0);
    send(mk(ACT_READ, 4 * NSRC, 0, 0, 0, 1'b0), 0);
    send(mk(ACT_WRITE, 32'h20_4000, 32'h5), 0);
    send(mk(ACT_READ, 32'h20_0008, 0), 0);
    send(mk(ACT_REFRESH, 0, 0), 0);

    rand_phase(450, 19);
    set_base(32'hFFC0_0000);
    rand_phase(400, 64);
    set_base(32'h1234_5000);
    rand_phase(330, 0);
    set_base(32'hFFFF_FFFF);
    rand_phase(40, 19);
    send(mk(ACT_READ, 0, 0), 0);
    drain();

    $display("covered %0d items, %0d results, %0d claims that found a winner",
             sb.n_items, sb.n_results, sb.n_claims);
    $display("window base moved across 0, 0xFFC00000, 0x12345000 and 0xFFFFFFFF");
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("platform_interrupt_controller_tb: PASS");
    end else begin
      if (sb.owed_q.size() != 0) $error("%0d results never arrived", sb.owed_q.size());
      $display("platform_interrupt_controller_tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/pic_pkg.sv
hdl/pic_ctrl.sv
hdl/pic_dp.sv
hdl/platform_interrupt_controller.sv
sim/platform_interrupt_controller_tb.sv
